// ===== rtl/hung_pkg.sv =====
// Package: shared types, constants and the controller-to-datapath command and status structs.
package hung_pkg;

    localparam int MAX_ROWS_DEF   = 16;
    localparam int MAX_COLS_DEF   = 16;
    localparam int COST_WIDTH_DEF = 16;
    localparam int POT_WIDTH_DEF  = 32;
    localparam int DIM_W          = 5;
    localparam int IDX_W          = 4;
    localparam int ENTRY_W        = 16;
    localparam int TOTAL_W        = 20;
    localparam logic REG_ROWS     = 1'b0;
    localparam logic REG_COLS     = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_AUG_INIT,
        ST_SCAN,
        ST_SCAN_END,
        ST_UPDATE,
        ST_NEXT,
        ST_BACK,
        ST_ROW_NEXT,
        ST_EMIT,
        ST_EMIT_WAIT
    } t_state;

    typedef struct packed {
        logic clear_all;
        logic aug_init;
        logic scan_start;
        logic scan_step;
        logic update_step;
        logic next_col;
        logic back_step;
        logic emit_load;
        logic emit_step;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic abort;
        logic path_open;
        logic update_done;
        logic back_done;
        logic emit_done;
    } t_status;

endpackage

// ===== rtl/hungarian_assignment_core.sv =====
// Each accepted cost entry is stored; the final entry starts a solve of min(rows,cols) rows.
// Each row runs at most cols+1 search steps, each a scan and a potential update, then flips its
// augmenting path; results then follow one row at a time, held while the receiver stalls.
// Throughput: one entry per cycle while loading; no entry is taken while a solve or its
// output runs.
// Reset: synchronous active low; registers return to sixteen rows and sixteen columns.
module hungarian_assignment_core #(
    parameter int MAX_ROWS   = hung_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS   = hung_pkg::MAX_COLS_DEF,
    parameter int COST_WIDTH = hung_pkg::COST_WIDTH_DEF,
    parameter int POT_WIDTH  = hung_pkg::POT_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic                                i_cfg_index,
    input  logic [hung_pkg::DIM_W-1:0]          i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [hung_pkg::IDX_W-1:0]          i_row_index,
    input  logic [hung_pkg::IDX_W-1:0]          i_col_index,
    input  logic signed [hung_pkg::ENTRY_W-1:0] i_entry_cost,
    input  logic                                i_last_entry,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [hung_pkg::IDX_W-1:0]          o_out_row,
    output logic [hung_pkg::IDX_W-1:0]          o_assigned_column,
    output logic                                o_is_assigned,
    output logic signed [hung_pkg::TOTAL_W-1:0] o_running_total,
    output logic                                o_last_result
);
    import hung_pkg::*;

    logic [DIM_W-1:0] r_rows, r_cols;
    t_cmd    w_cmd;
    t_status w_status;
    logic w_busy, w_row_next, w_last_row, w_out_free, w_acc;

    assign o_cfg_ready = 1'b1;
    assign o_stall = w_busy;
    assign w_acc = i_valid && !w_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= DIM_W'(16);
            r_cols <= DIM_W'(16);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ROWS: r_rows <= i_cfg_data;
                REG_COLS: r_cols <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    hung_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_acc && i_last_entry),
        .i_last_row (w_last_row),
        .i_out_free (w_out_free),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_row_next (w_row_next),
        .o_busy     (w_busy)
    );

    hung_dpath #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .COST_WIDTH (COST_WIDTH),
        .POT_WIDTH  (POT_WIDTH)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_wr_en           (w_acc),
        .i_wr_row          (i_row_index),
        .i_wr_col          (i_col_index),
        .i_wr_cost         (i_entry_cost),
        .i_rows_cfg        (r_rows),
        .i_cols_cfg        (r_cols),
        .i_cmd             (w_cmd),
        .i_row_next        (w_row_next),
        .o_status          (w_status),
        .o_last_row        (w_last_row),
        .o_out_free        (w_out_free),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_out_row         (o_out_row),
        .o_assigned_column (o_assigned_column),
        .o_is_assigned     (o_is_assigned),
        .o_running_total   (o_running_total),
        .o_last_result     (o_last_result)
    );

endmodule

// ===== rtl/hung_ctrl.sv =====
// Controller: sequences clearing, augmentation search, potential update, path flip and output.
module hung_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_last_row,
    input  logic             i_out_free,
    input  hung_pkg::t_status i_status,
    output hung_pkg::t_cmd   o_cmd,
    output logic             o_row_next,
    output logic             o_busy
);
    import hung_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_row_next = 1'b0;
        o_busy     = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.clear_all = 1'b1;
                    n_state = ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                n_state = ST_AUG_INIT;
            end
            ST_AUG_INIT: begin
                if (i_last_row) begin
                    o_cmd.emit_load = 1'b1;
                    n_state = ST_EMIT;
                end else begin
                    o_cmd.aug_init = 1'b1;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_start = 1'b1;
                n_state = ST_SCAN_END;
            end
            ST_SCAN_END: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_done) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (i_status.abort) begin
                    n_state = ST_ROW_NEXT;
                end else begin
                    o_cmd.update_step = 1'b1;
                    if (i_status.update_done) begin
                        n_state = ST_NEXT;
                    end
                end
            end
            ST_NEXT: begin
                o_cmd.next_col = 1'b1;
                if (i_status.path_open) begin
                    n_state = ST_SCAN;
                end else begin
                    n_state = ST_BACK;
                end
            end
            ST_BACK: begin
                o_cmd.back_step = 1'b1;
                if (i_status.back_done) begin
                    n_state = ST_ROW_NEXT;
                end
            end
            ST_ROW_NEXT: begin
                o_row_next = 1'b1;
                n_state = ST_AUG_INIT;
            end
            ST_EMIT: begin
                if (i_out_free) begin
                    o_cmd.emit_step = 1'b1;
                    if (i_status.emit_done) begin
                        n_state = ST_EMIT_WAIT;
                    end
                end
            end
            ST_EMIT_WAIT: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/hung_dpath.sv =====
// Datapath: cost memory, potentials, slack minima, match table and the result stage.
module hung_dpath #(
    parameter int MAX_ROWS   = hung_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS   = hung_pkg::MAX_COLS_DEF,
    parameter int COST_WIDTH = hung_pkg::COST_WIDTH_DEF,
    parameter int POT_WIDTH  = hung_pkg::POT_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_wr_en,
    input  logic [hung_pkg::IDX_W-1:0]   i_wr_row,
    input  logic [hung_pkg::IDX_W-1:0]   i_wr_col,
    input  logic signed [hung_pkg::ENTRY_W-1:0] i_wr_cost,
    input  logic [hung_pkg::DIM_W-1:0]   i_rows_cfg,
    input  logic [hung_pkg::DIM_W-1:0]   i_cols_cfg,
    input  hung_pkg::t_cmd               i_cmd,
    input  logic                         i_row_next,
    output hung_pkg::t_status            o_status,
    output logic                         o_last_row,
    output logic                         o_out_free,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [hung_pkg::IDX_W-1:0]   o_out_row,
    output logic [hung_pkg::IDX_W-1:0]   o_assigned_column,
    output logic                         o_is_assigned,
    output logic signed [hung_pkg::TOTAL_W-1:0] o_running_total,
    output logic                         o_last_result
);
    import hung_pkg::*;

    localparam int RW = $clog2(MAX_ROWS + 1);
    localparam int CW = $clog2(MAX_COLS + 1);
    localparam int RA = $clog2(MAX_ROWS);
    localparam int CA = $clog2(MAX_COLS);
    localparam int DEPTH = 1 << (RA + CA);
    localparam logic signed [POT_WIDTH-1:0] POT_MAX = {1'b0, {(POT_WIDTH-1){1'b1}}};
    localparam logic signed [POT_WIDTH-1:0] POT_MIN = {1'b1, {(POT_WIDTH-1){1'b0}}};
    localparam logic signed [COST_WIDTH-1:0] CMAX = {1'b0, {(COST_WIDTH-1){1'b1}}};
    localparam logic signed [COST_WIDTH-1:0] CMIN = {1'b1, {(COST_WIDTH-1){1'b0}}};
    localparam logic signed [TOTAL_W-1:0] TMAX = {1'b0, {(TOTAL_W-1){1'b1}}};
    localparam logic signed [TOTAL_W-1:0] TMIN = {1'b1, {(TOTAL_W-1){1'b0}}};
    localparam int XW = (POT_WIDTH > COST_WIDTH ? POT_WIDTH : COST_WIDTH) + 2;

    function automatic logic signed [POT_WIDTH-1:0] sat(input logic signed [XW-1:0] x);
        logic signed [XW-1:0] hi, lo;
        begin
            hi = XW'(POT_MAX);
            lo = XW'(POT_MIN);
            if (x > hi) begin
                sat = POT_MAX;
            end else if (x < lo) begin
                sat = POT_MIN;
            end else begin
                sat = x[POT_WIDTH-1:0];
            end
        end
    endfunction

    logic signed [COST_WIDTH-1:0] r_cost_mem [DEPTH];
    logic signed [COST_WIDTH-1:0] r_cost_rd;
    logic signed [POT_WIDTH-1:0] r_u [MAX_ROWS+1];
    logic signed [POT_WIDTH-1:0] r_v [MAX_COLS+1];
    logic signed [POT_WIDTH-1:0] r_minv [MAX_COLS+1];
    logic [RW-1:0] r_p [MAX_COLS+1];
    logic [CW-1:0] r_way [MAX_COLS+1];
    logic [MAX_COLS:0] r_used;

    logic [RW-1:0] r_row;
    logic [CW-1:0] r_j0, r_j1, r_j, r_jr, r_guard;
    logic [RW-1:0] r_i0;
    logic r_rd_ok;
    logic signed [POT_WIDTH-1:0] r_delta;
    logic [RW-1:0] r_nr;
    logic [CW-1:0] r_nc;

    logic signed [COST_WIDTH-1:0] n_cost_in;
    logic [RA+CA-1:0] w_rd_addr;
    logic [CW-1:0] w_jm1;
    logic [RW-1:0] w_steps;

    // Saturation of the incoming cost to the stored width.
    always_comb begin
        n_cost_in = CMIN;
        if (XW'(i_wr_cost) > XW'(CMAX)) begin
            n_cost_in = CMAX;
        end else if (XW'(i_wr_cost) >= XW'(CMIN)) begin
            n_cost_in = COST_WIDTH'(i_wr_cost);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_all) begin
            if (i_rows_cfg == '0) begin
                r_nr <= RW'(1);
            end else if (32'(i_rows_cfg) > MAX_ROWS) begin
                r_nr <= RW'(MAX_ROWS);
            end else begin
                r_nr <= RW'(i_rows_cfg);
            end
            if (i_cols_cfg == '0) begin
                r_nc <= CW'(1);
            end else if (32'(i_cols_cfg) > MAX_COLS) begin
                r_nc <= CW'(MAX_COLS);
            end else begin
                r_nc <= CW'(i_cols_cfg);
            end
        end
    end

    assign w_steps = (32'(r_nr) < 32'(r_nc)) ? r_nr : RW'(r_nc);
    assign o_last_row = (r_row >= w_steps);

    function automatic logic [CW-1:0] r_p_col_of_row(input logic [RW-1:0] row);
        logic [CW-1:0] col;
        begin
            col = '0;
            for (int k = 1; k <= MAX_COLS; k++) begin
                if (r_p[k] == RW'(row + 1'b1)) begin
                    col = CW'(k - 1);
                end
            end
            r_p_col_of_row = col;
        end
    endfunction

    // Cost memory with one write and one registered read port.
    logic [RW-1:0] w_rd_row;
    logic [CW-1:0] w_rd_col;
    logic [RW-1:0] r_emit_row;
    logic          r_emit_phase;
    always_comb begin
        w_rd_row = '0;
        w_rd_col = '0;
        if (r_emit_phase) begin
            w_rd_row = r_emit_row;
            w_rd_col = CW'(r_p_col_of_row(r_emit_row));
        end else begin
            w_rd_row = (r_i0 == '0) ? '0 : RW'(r_i0 - 1'b1);
            w_rd_col = (r_j == '0) ? '0 : CW'(r_j - 1'b1);
        end
    end

    assign w_jm1 = w_rd_col;
    assign w_rd_addr = {w_rd_row[RA-1:0], w_jm1[CA-1:0]};

    always_ff @(posedge i_clk) begin
        if (i_wr_en && (32'(i_wr_row) < MAX_ROWS) && (32'(i_wr_col) < MAX_COLS)) begin
            r_cost_mem[{RA'(i_wr_row), CA'(i_wr_col)}] <= n_cost_in;
        end
        r_cost_rd <= r_cost_mem[w_rd_addr];
    end

    // Search loop: one column each cycle, slack compare against a running minimum.
    logic signed [POT_WIDTH-1:0] w_cur, w_slack;
    logic w_col_live;
    always_comb begin
        w_cur = sat((r_rd_ok ? XW'(r_cost_rd) : XW'(0)) - XW'(r_u[r_i0]) - XW'(r_v[r_jr]));
        w_slack = r_minv[r_jr];
        if (w_cur < r_minv[r_jr]) begin
            w_slack = w_cur;
        end
        w_col_live = (r_jr != '0) && (r_jr <= r_nc) && !r_used[r_jr];
    end

    logic w_any_used;
    logic [RW-1:0] w_r;
    always_comb begin
        w_r = r_p[r_j];
        if (w_r > r_nr) begin
            w_r = '0;
        end
        w_any_used = r_used[r_j];
    end

    assign o_status.scan_done   = (r_jr == r_nc);
    assign o_status.abort       = (r_delta >= POT_MAX);
    assign o_status.update_done = (r_j == r_nc);
    assign o_status.path_open   = (r_p[r_j1] != '0) && (r_j1 != '0) && (r_guard < r_nc);
    assign o_status.back_done   = (r_way[r_j0] == '0) || (r_guard > r_nc);

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_all) begin
            for (int k = 0; k <= MAX_ROWS; k++) begin
                r_u[k] <= '0;
            end
            for (int k = 0; k <= MAX_COLS; k++) begin
                r_v[k] <= '0;
                r_p[k] <= '0;
            end
            r_row <= '0;
        end
        if (i_row_next) begin
            r_row <= RW'(r_row + 1'b1);
        end
        if (i_cmd.aug_init) begin
            for (int k = 0; k <= MAX_COLS; k++) begin
                r_way[k]  <= '0;
                r_minv[k] <= POT_MAX;
            end
            r_used <= '0;
            r_p[0] <= RW'(r_row + 1'b1);
            r_j0 <= '0;
            r_guard <= '0;
        end
        if (i_cmd.scan_start) begin
            r_used[r_j0] <= 1'b1;
            r_i0 <= (r_p[r_j0] > r_nr) ? '0 : r_p[r_j0];
            r_rd_ok <= (r_p[r_j0] != '0) && (r_p[r_j0] <= r_nr);
            r_j <= CW'(1);
            r_jr <= '0;
            r_delta <= POT_MAX;
            r_j1 <= '0;
        end
        if (i_cmd.scan_step) begin
            r_j <= CW'(r_j + 1'b1);
            r_jr <= r_j;
            if (w_col_live) begin
                if (w_cur < r_minv[r_jr]) begin
                    r_minv[r_jr] <= w_cur;
                    r_way[r_jr] <= r_j0;
                end
                if (w_slack < r_delta) begin
                    r_delta <= w_slack;
                    r_j1 <= r_jr;
                end
            end
            if (o_status.scan_done) begin
                r_j <= '0;
            end
        end
        if (i_cmd.update_step) begin
            r_j <= CW'(r_j + 1'b1);
            if (w_any_used) begin
                r_u[w_r] <= sat(XW'(r_u[w_r]) + XW'(r_delta));
                r_v[r_j] <= sat(XW'(r_v[r_j]) - XW'(r_delta));
            end else begin
                r_minv[r_j] <= sat(XW'(r_minv[r_j]) - XW'(r_delta));
            end
        end
        if (i_cmd.next_col) begin
            r_j0 <= r_j1;
            r_guard <= CW'(r_guard + 1'b1);
            if (!o_status.path_open) begin
                r_guard <= '0;
            end
        end
        if (i_cmd.back_step) begin
            r_p[r_j0] <= r_p[r_way[r_j0]];
            r_j0 <= r_way[r_j0];
            r_guard <= CW'(r_guard + 1'b1);
        end
    end

    // Result stage: for each row, a memory read phase, then a total and register phase.
    logic r_half, r_ovalid;
    logic signed [TOTAL_W-1:0] r_total;
    logic [CW-1:0] r_col_hold;
    logic r_ok_hold;
    logic signed [TOTAL_W+COST_WIDTH:0] w_sum;

    assign o_out_free = !r_ovalid || !i_stall;
    assign o_status.emit_done = r_half && (32'(r_emit_row) + 1 == 32'(r_nr));
    assign w_sum = (TOTAL_W+COST_WIDTH+1)'(r_total) + (TOTAL_W+COST_WIDTH+1)'(r_cost_rd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit_phase <= 1'b0;
            r_half <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (i_cmd.emit_load) begin
                r_emit_phase <= 1'b1;
                r_emit_row <= '0;
                r_half <= 1'b0;
                r_total <= '0;
            end
            if (i_cmd.emit_step) begin
                r_half <= !r_half;
                if (!r_half) begin
                    r_col_hold <= r_p_col_of_row(r_emit_row);
                    r_ok_hold <= 1'b0;
                    for (int k = 1; k <= MAX_COLS; k++) begin
                        if (32'(k) <= 32'(r_nc) && r_p[k] == RW'(r_emit_row + 1'b1)) begin
                            r_ok_hold <= 1'b1;
                        end
                    end
                end else begin
                    r_ovalid <= 1'b1;
                    o_out_row <= IDX_W'(r_emit_row);
                    o_assigned_column <= r_ok_hold ? IDX_W'(r_col_hold) : '0;
                    o_is_assigned <= r_ok_hold;
                    o_last_result <= o_status.emit_done;
                    if (r_ok_hold) begin
                        if (w_sum > (TOTAL_W+COST_WIDTH+1)'(TMAX)) begin
                            r_total <= TMAX;
                            o_running_total <= TMAX;
                        end else if (w_sum < (TOTAL_W+COST_WIDTH+1)'(TMIN)) begin
                            r_total <= TMIN;
                            o_running_total <= TMIN;
                        end else begin
                            r_total <= w_sum[TOTAL_W-1:0];
                            o_running_total <= w_sum[TOTAL_W-1:0];
                        end
                    end else begin
                        o_running_total <= r_total;
                    end
                    r_emit_row <= RW'(r_emit_row + 1'b1);
                    if (o_status.emit_done) begin
                        r_emit_phase <= 1'b0;
                    end
                end
            end
        end
    end

    assign o_valid = r_ovalid;

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the Hungarian assignment core: random cost matrices against a predictor.
module tb;
    import hung_pkg::*;

    localparam longint POT_MAX   = 64'sd2147483647;
    localparam longint POT_MIN   = -64'sd2147483648;
    localparam longint TOT_MAX   = 524287;
    localparam longint TOT_MIN   = -524288;
    localparam int     N_ITEMS   = 360;
    localparam int     CYC_LIMIT = 1000000;
    localparam int     SETTLE    = 64;

    typedef struct packed {
        logic [IDX_W-1:0]          row;
        logic [IDX_W-1:0]          col;
        logic signed [ENTRY_W-1:0] cost;
        logic                      last;
    } t_entry;

    typedef struct packed {
        logic [IDX_W-1:0]          row;
        logic [IDX_W-1:0]          col;
        logic                      assigned;
        logic signed [TOTAL_W-1:0] total;
        logic                      last;
    } t_match;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic                      i_cfg_index = REG_ROWS;
    logic [DIM_W-1:0]          i_cfg_data = '0;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    logic [IDX_W-1:0]          i_row_index = '0;
    logic [IDX_W-1:0]          i_col_index = '0;
    logic signed [ENTRY_W-1:0] i_entry_cost = '0;
    logic                      i_last_entry = 1'b0;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic [IDX_W-1:0]          o_out_row;
    logic [IDX_W-1:0]          o_assigned_column;
    logic                      o_is_assigned;
    logic signed [TOTAL_W-1:0] o_running_total;
    logic                      o_last_result;

    hungarian_assignment_core i_dut (.*);

    always #5 i_clk = ~i_clk;

    t_entry pending_entries[$];
    t_match expected_matches[$];
    int     errors = 0;
    int     cyc = 0;
    int     hold_left = 0;
    bit     hold_go = 1'b0;
    bit     hold_used = 1'b0;
    bit     quiet = 1'b0;

    logic [DIM_W-1:0] cfg_rows = 5'd16;
    logic [DIM_W-1:0] cfg_cols = 5'd16;

    longint cost_mem[256];
    longint row_pot[17];
    longint col_pot[17];
    longint slack[17];
    int     col_owner[17];
    int     prev_col[17];
    bit     visited[17];

    function automatic longint sat_pot(longint x);
        if (x > POT_MAX) return POT_MAX;
        if (x < POT_MIN) return POT_MIN;
        return x;
    endfunction

    function automatic int eff_dim(logic [DIM_W-1:0] v);
        if (v == 0) return 1;
        return (v > 16) ? 16 : int'(v);
    endfunction

    function automatic void augment(int row, int nr, int nc);
        int j, j0, j1, i0, r, guard;
        longint delta, cur, c;
        bit aborted;
        for (j = 0; j <= nc; j++) begin
            prev_col[j] = 0;
            slack[j] = POT_MAX;
            visited[j] = 1'b0;
        end
        col_owner[0] = row + 1;
        j0 = 0;
        guard = 0;
        aborted = 1'b0;
        do begin
            j1 = 0;
            delta = POT_MAX;
            visited[j0] = 1'b1;
            i0 = col_owner[j0];
            if (i0 > nr) i0 = 0;
            for (j = 1; j <= nc; j++) begin
                if (!visited[j]) begin
                    c = (i0 > 0) ? cost_mem[(i0 - 1) * 16 + j - 1] : 0;
                    cur = sat_pot(c - row_pot[i0] - col_pot[j]);
                    if (cur < slack[j]) begin
                        slack[j] = cur;
                        prev_col[j] = j0;
                    end
                    if (slack[j] < delta) begin
                        delta = slack[j];
                        j1 = j;
                    end
                end
            end
            if (delta >= POT_MAX) begin
                aborted = 1'b1;
                break;
            end
            for (j = 0; j <= nc; j++) begin
                if (visited[j]) begin
                    r = col_owner[j];
                    if (r > nr) r = 0;
                    row_pot[r] = sat_pot(row_pot[r] + delta);
                    col_pot[j] = sat_pot(col_pot[j] - delta);
                end else begin
                    slack[j] = sat_pot(slack[j] - delta);
                end
            end
            j0 = j1;
            guard++;
        end while (col_owner[j0] != 0 && j0 != 0 && guard <= nc);
        if (aborted) return;
        guard = 0;
        do begin
            j1 = prev_col[j0];
            col_owner[j0] = col_owner[j1];
            j0 = j1;
            guard++;
        end while (j0 != 0 && guard <= nc + 1);
    endfunction

    function automatic void solve_assignment();
        int nr, nc, i, j;
        int owner_col[16];
        longint total;
        t_match m;
        nr = eff_dim(cfg_rows);
        nc = eff_dim(cfg_cols);
        total = 0;
        for (i = 0; i <= 16; i++) begin
            row_pot[i] = 0;
            col_pot[i] = 0;
            col_owner[i] = 0;
        end
        for (i = 0; i < ((nr < nc) ? nr : nc); i++) augment(i, nr, nc);
        for (i = 0; i < 16; i++) owner_col[i] = -1;
        for (j = 1; j <= nc; j++)
            if (col_owner[j] != 0 && col_owner[j] <= nr) owner_col[col_owner[j] - 1] = j - 1;
        for (i = 0; i < nr; i++) begin
            if (owner_col[i] >= 0) begin
                total += cost_mem[i * 16 + owner_col[i]];
                if (total > TOT_MAX) total = TOT_MAX;
                if (total < TOT_MIN) total = TOT_MIN;
            end
            m.row = i[IDX_W-1:0];
            m.col = (owner_col[i] >= 0) ? owner_col[i][IDX_W-1:0] : '0;
            m.assigned = (owner_col[i] >= 0);
            m.total = total[TOTAL_W-1:0];
            m.last = (i + 1 == nr);
            expected_matches.push_back(m);
        end
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (quiet || p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // Sender side.
    int send_gap = 0;
    always @(posedge i_clk) begin
        t_entry e;
        bit free;
        free = !i_valid;
        if (i_rst_n && i_valid && !o_stall) begin
            cost_mem[i_row_index * 16 + i_col_index] = i_entry_cost;
            if (i_last_entry) solve_assignment();
            free = 1'b1;
            send_gap = gap_len();
        end
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (free) begin
            if (send_gap > 0 || pending_entries.size() == 0) begin
                if (send_gap > 0) send_gap--;
                i_valid <= 1'b0;
            end else begin
                e = pending_entries.pop_front();
                i_valid <= 1'b1;
                i_row_index <= e.row;
                i_col_index <= e.col;
                i_entry_cost <= e.cost;
                i_last_entry <= e.last;
            end
        end
    end

    // Receiver side.
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_match m;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_matches.size() == 0) begin
                report("unexpected result row", o_out_row, -1);
            end else begin
                m = expected_matches.pop_front();
                if (o_out_row !== m.row) report("out_row", o_out_row, m.row);
                if (o_is_assigned !== m.assigned)
                    report("is_assigned", o_is_assigned, m.assigned);
                if (o_assigned_column !== m.col)
                    report("assigned_column", o_assigned_column, m.col);
                if (o_running_total !== m.total)
                    report("running_total", o_running_total, m.total);
                if (o_last_result !== m.last) report("last_result", o_last_result, m.last);
            end
        end
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else begin
            stall_left = gap_len();
            i_stall <= (stall_left > 0);
        end
    end

    // Long receiver hold-off, started once by the stimulus.
    always @(posedge i_clk) begin
        if (hold_go && !hold_used) begin
            hold_left <= 400;
            hold_used <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc >= CYC_LIMIT) begin
            $display("FAIL hungarian_assignment_core");
            $finish;
        end
    end

    task automatic write_reg(logic idx, logic [DIM_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_ROWS) cfg_rows = val;
        else cfg_cols = val;
    endtask

    task automatic wait_idle();
        while (pending_entries.size() != 0 || expected_matches.size() != 0 || i_valid)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    bit written[256];
    int queued = 0;

    function automatic logic signed [ENTRY_W-1:0] pick_cost(int style);
        case (style)
            0: return ENTRY_W'($urandom());
            1: return ENTRY_W'(int'($urandom_range(0, 2047)) - 1024);
            2: return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
            default: return ENTRY_W'($urandom_range(0, 7) << 8);
        endcase
    endfunction

    task automatic run_matrix(logic [DIM_W-1:0] r_cfg, logic [DIM_W-1:0] c_cfg, int style,
                              bit chain);
        t_entry e;
        int nr, nc, k, extra;
        if (!chain) begin
            wait_idle();
            write_reg(REG_ROWS, r_cfg);
            write_reg(REG_COLS, c_cfg);
        end
        quiet = ($urandom_range(0, 3) == 0);
        nr = eff_dim(r_cfg);
        nc = eff_dim(c_cfg);
        for (k = 0; k < 256; k++) begin
            if ((k / 16) < nr && (k % 16) < nc && (!written[k] || $urandom_range(0, 2) == 0)) begin
                e.row = IDX_W'(k / 16);
                e.col = IDX_W'(k % 16);
                e.cost = pick_cost(style);
                e.last = 1'b0;
                written[k] = 1'b1;
                pending_entries.push_back(e);
                queued++;
            end
        end
        extra = $urandom_range(0, 3);
        for (k = 0; k <= extra; k++) begin
            e.row = IDX_W'($urandom_range(0, 15));
            e.col = IDX_W'($urandom_range(0, 15));
            e.cost = pick_cost(style);
            e.last = (k == extra);
            written[e.row * 16 + e.col] = 1'b1;
            pending_entries.push_back(e);
            queued++;
        end
    endtask

    initial begin
        int d, rc, cc;
        for (d = 0; d < 256; d++) cost_mem[d] = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_matrix(5'd2, 5'd2, 2, 1'b0);
        run_matrix(5'd0, 5'd0, 0, 1'b0);
        run_matrix(5'd3, 5'd2, 1, 1'b0);
        run_matrix(5'd2, 5'd3, 3, 1'b0);
        run_matrix(5'd1, 5'd31, 0, 1'b0);
        run_matrix(5'd16, 5'd1, 2, 1'b0);
        run_matrix(5'd3, 5'd3, 1, 1'b0);
        hold_go = 1'b1;
        run_matrix(5'd3, 5'd3, 3, 1'b1);
        while (queued < N_ITEMS) begin
            d = $urandom_range(0, 19);
            if (d == 0 && queued + 256 <= N_ITEMS) begin
                rc = 16;
                cc = 16;
            end else if (d < 3) begin
                rc = $urandom_range(0, 31);
                cc = $urandom_range(1, 4);
            end else begin
                rc = $urandom_range(1, 5);
                cc = $urandom_range(1, 5);
            end
            run_matrix(rc[DIM_W-1:0], cc[DIM_W-1:0], $urandom_range(0, 3), 1'b0);
        end
        wait_idle();
        if (errors == 0) begin
            $display("PASS hungarian_assignment_core");
        end else begin
            $display("FAIL hungarian_assignment_core");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/hung_pkg.sv
rtl/hung_ctrl.sv
rtl/hung_dpath.sv
rtl/hungarian_assignment_core.sv
verif/tb.sv
